// ===== hw/rtl/sparse_table_range_minimum_defines.svh =====
// Assertion macros shared by the sparse table range minimum RTL.
`ifndef SPARSE_TABLE_RANGE_MINIMUM_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MINIMUM_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define STRM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The condition must never hold outside reset.
`define STRM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== hw/rtl/strm_pkg.sv =====
// Package with the shared types, constants and functions of the sparse table block.
package strm_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 10;
   localparam int VAL_W    = 32;
   localparam int CSR_W    = 11;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = POS_W + 1;
   localparam int LOG_W    = $clog2(LEN_W);

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_RANGE = 2'd1,
      ST_NOT_BUILT = 2'd2,
      ST_BAD_LOAD  = 2'd3
   } status_type;

   // What the back end has to do with a queued command.
   typedef enum logic [1:0] {
      KIND_REPLY = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_BUILD = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      status_type status;
   } cmd_ctl_type;

   function automatic logic signed [VAL_W-1:0] smin(input logic signed [VAL_W-1:0] a,
                                                    input logic signed [VAL_W-1:0] b);
      return (a <= b) ? a : b;
   endfunction

   function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] x);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int i = 0; i < LEN_W; i++) begin
         if (x[i]) k = LOG_W'(i);
      end
      return k;
   endfunction

endpackage

// ===== hw/rtl/strm_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module strm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hw/rtl/strm_queue.sv =====
// Short command queue between the front end and the back end.
`include "sparse_table_range_minimum_defines.svh"

module strm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `STRM_ASSERT_IMPLIES(a_queue_no_overflow, clock, reset, push, !full, "push into a full queue")
   `STRM_ASSERT_IMPLIES(a_queue_no_underflow, clock, reset, pop, !empty, "pop from an empty queue")

endmodule

// ===== hw/rtl/strm_front.sv =====
// Front end: accepts request words, holds the count register and built mark, classifies.
module strm_front import strm_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 11,
   parameter int IDX_W        = 10,
   parameter int LVL_W        = 4,
   parameter int CNT_W        = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0]        req_left,
   input  logic [POS_W-1:0]        req_right,
   input  logic                    csr_wr_en,
   input  logic [CSR_W-1:0]        csr_wr_data,
   input  logic                    q_full,
   output logic                    q_push,
   output cmd_ctl_type             cmd_ctl,
   output logic [LVL_W-1:0]        cmd_level,
   output logic [IDX_W-1:0]        cmd_addr_a,
   output logic [IDX_W-1:0]        cmd_addr_b,
   output logic signed [VAL_W-1:0] cmd_value,
   output logic [CNT_W-1:0]        active_count
);

   logic [CSR_W-1:0] count_ff, count_in;
   logic             built_ff, built_in;
   logic [CNT_W-1:0] pos_x;
   logic [CNT_W-1:0] right_x;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] span;
   logic [LEN_W-1:0] b_full;
   logic [LOG_W-1:0] k_raw;
   logic [LVL_W-1:0] k_lvl;

   // A count above the table size acts as the table size.
   assign active_count = (CNT_W'(count_ff) > CNT_W'(MAX_ELEMENTS)) ?
                         CNT_W'(MAX_ELEMENTS) : CNT_W'(count_ff);

   assign pos_x   = CNT_W'(req_position);
   assign right_x = CNT_W'(req_right);

   // Window level and the start of the second, right-aligned window.
   assign len    = LEN_W'(req_right) - LEN_W'(req_left) + LEN_W'(1);
   assign k_raw  = floor_log2(len);
   assign k_lvl  = (int'(k_raw) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(k_raw);
   assign span   = LEN_W'(1) << k_lvl;
   assign b_full = LEN_W'(req_right) + LEN_W'(1) - span;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign cmd_value = req_value;

   always_comb begin
      cmd_ctl.kind   = KIND_REPLY;
      cmd_ctl.status = ST_OK;
      cmd_level      = '0;
      cmd_addr_a     = '0;
      cmd_addr_b     = '0;
      unique case (req_operation)
         OP_LOAD: begin
            if (pos_x >= active_count) begin
               cmd_ctl.status = ST_BAD_LOAD;
            end else begin
               cmd_ctl.kind = KIND_LOAD;
               cmd_addr_a   = IDX_W'(req_position);
            end
         end
         OP_BUILD: begin
            // With fewer than two elements there is no level to fill.
            if (active_count >= CNT_W'(2)) cmd_ctl.kind = KIND_BUILD;
         end
         OP_QUERY: begin
            if (!built_ff) begin
               cmd_ctl.status = ST_NOT_BUILT;
            end else if ((req_left > req_right) || (right_x >= active_count)) begin
               cmd_ctl.status = ST_BAD_RANGE;
            end else begin
               cmd_ctl.kind = KIND_QUERY;
               cmd_level    = k_lvl;
               cmd_addr_a   = IDX_W'(req_left);
               cmd_addr_b   = IDX_W'(b_full);
            end
         end
         default: begin
            cmd_ctl.kind = KIND_REPLY;
         end
      endcase
   end

   always_comb begin
      built_in = built_ff;
      count_in = count_ff;
      if (q_push) begin
         if ((req_operation == OP_LOAD) && (pos_x < active_count)) built_in = 1'b0;
         if (req_operation == OP_BUILD) built_in = 1'b1;
      end
      if (csr_wr_en) begin
         count_in = csr_wr_data;
         built_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CSR_RESET;
         built_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         built_ff <= built_in;
      end
   end

endmodule

// ===== hw/rtl/strm_back.sv =====
// Back end: table memory, build sequencer, query compare and response register.
`include "sparse_table_range_minimum_defines.svh"

module strm_back import strm_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 11,
   parameter int IDX_W        = 10,
   parameter int LVL_W        = 4,
   parameter int CNT_W        = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  cmd_ctl_type             cmd_ctl,
   input  logic [LVL_W-1:0]        cmd_level,
   input  logic [IDX_W-1:0]        cmd_addr_a,
   input  logic [IDX_W-1:0]        cmd_addr_b,
   input  logic signed [VAL_W-1:0] cmd_value,
   input  logic [CNT_W-1:0]        active_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_minimum,
   output logic [STATUS_W-1:0]     rsp_status
);

   localparam int AW        = LVL_W + IDX_W;
   localparam int RAM_DEPTH = LEVELS * (1 << IDX_W);

   logic out_ready, s1_free, s1_advance;
   logic pop_load, pop_build, pop_query;

   logic             bld_busy_ff, bld_busy_in;
   logic             bld_drain_ff, bld_drain_in;
   logic [LVL_W-1:0] bld_lvl_ff, bld_lvl_in;
   logic [IDX_W-1:0] bld_idx_ff, bld_idx_in;
   logic             bld_run, bld_last, bld_more, bld_done;
   logic [LVL_W-1:0] bld_lvl_prev;
   logic [LVL_W:0]   bld_lvl_next;
   logic [CNT_W-1:0] bld_span;
   logic [CNT_W-1:0] bld_half_idx;
   logic [CNT_W:0]   bld_next_span;

   logic          bw_valid_ff, bw_valid_in;
   logic [AW-1:0] bw_addr_ff, bw_addr_in;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_query_ff, s1_query_in;
   status_type s1_status_ff, s1_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_minimum_ff, rsp_minimum_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [AW-1:0]           ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [VAL_W-1:0]        ram_wr_data, ram_rd_data_a, ram_rd_data_b;
   logic signed [VAL_W-1:0] pair_min;

   // Handshake between the result stage and the response register.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_ready;
   assign s1_free    = !s1_valid_ff || out_ready;

   assign q_pop     = q_valid && s1_free && !bld_busy_ff;
   assign pop_load  = q_pop && (cmd_ctl.kind == KIND_LOAD);
   assign pop_build = q_pop && (cmd_ctl.kind == KIND_BUILD);
   assign pop_query = q_pop && (cmd_ctl.kind == KIND_QUERY);

   // Build walk: level k at j is the minimum of level k-1 at j and j + 2^(k-1).
   assign bld_run       = bld_busy_ff && !bld_drain_ff;
   assign bld_lvl_prev  = bld_lvl_ff - LVL_W'(1);
   assign bld_half_idx  = CNT_W'(bld_idx_ff) + (CNT_W'(1) << bld_lvl_prev);
   assign bld_span      = CNT_W'(1) << bld_lvl_ff;
   assign bld_last      = ((CNT_W'(bld_idx_ff) + bld_span) == active_count);
   assign bld_lvl_next  = (LVL_W + 1)'(bld_lvl_ff) + (LVL_W + 1)'(1);
   assign bld_next_span = (CNT_W + 1)'(1) << bld_lvl_next;
   assign bld_more      = (int'(bld_lvl_next) < LEVELS) &&
                          (bld_next_span <= (CNT_W + 1)'(active_count));
   assign bld_done      = bld_busy_ff && bld_drain_ff && !bld_more;

   assign pair_min = smin(ram_rd_data_a, ram_rd_data_b);

   always_comb begin
      ram_rd_en = bld_run || pop_query;
      if (bld_run) begin
         ram_rd_addr_a = {bld_lvl_prev, bld_idx_ff};
         ram_rd_addr_b = {bld_lvl_prev, IDX_W'(bld_half_idx)};
      end else begin
         ram_rd_addr_a = {cmd_level, cmd_addr_a};
         ram_rd_addr_b = {cmd_level, cmd_addr_b};
      end
      if (bw_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = bw_addr_ff;
         ram_wr_data = pair_min;
      end else begin
         ram_wr_en   = pop_load;
         ram_wr_addr = {LVL_W'(0), cmd_addr_a};
         ram_wr_data = cmd_value;
      end
   end

   always_comb begin
      bld_busy_in  = bld_busy_ff;
      bld_drain_in = bld_drain_ff;
      bld_lvl_in   = bld_lvl_ff;
      bld_idx_in   = bld_idx_ff;
      priority if (pop_build) begin
         bld_busy_in  = 1'b1;
         bld_drain_in = 1'b0;
         bld_lvl_in   = LVL_W'(1);
         bld_idx_in   = '0;
      end else if (bld_run) begin
         if (bld_last) begin
            bld_drain_in = 1'b1;
         end else begin
            bld_idx_in = bld_idx_ff + IDX_W'(1);
         end
      end else if (bld_busy_ff) begin
         // The drain state lets the last write of a level land before the next level reads it.
         if (bld_more) begin
            bld_lvl_in   = LVL_W'(bld_lvl_next);
            bld_idx_in   = '0;
            bld_drain_in = 1'b0;
         end else begin
            bld_busy_in = 1'b0;
         end
      end else begin
         bld_busy_in = 1'b0;
      end
      bw_valid_in = bld_run;
      bw_addr_in  = {bld_lvl_ff, bld_idx_ff};
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_query_in  = s1_query_ff;
      s1_status_in = s1_status_ff;
      priority if (q_pop && !pop_build) begin
         s1_valid_in  = 1'b1;
         s1_query_in  = pop_query;
         s1_status_in = cmd_ctl.status;
      end else if (bld_done) begin
         s1_valid_in  = 1'b1;
         s1_query_in  = 1'b0;
         s1_status_in = ST_OK;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_minimum_in = rsp_minimum_ff;
      rsp_status_in  = rsp_status_ff;
      if (s1_advance) begin
         rsp_valid_in   = 1'b1;
         rsp_minimum_in = s1_query_ff ? pair_min : '0;
         rsp_status_in  = s1_status_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bld_busy_ff  <= 1'b0;
         bld_drain_ff <= 1'b0;
         bw_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bld_busy_ff  <= bld_busy_in;
         bld_drain_ff <= bld_drain_in;
         bw_valid_ff  <= bw_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bld_lvl_ff     <= bld_lvl_in;
      bld_idx_ff     <= bld_idx_in;
      bw_addr_ff     <= bw_addr_in;
      s1_query_ff    <= s1_query_in;
      s1_status_ff   <= s1_status_in;
      rsp_minimum_ff <= rsp_minimum_in;
      rsp_status_ff  <= rsp_status_in;
   end

   strm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (RAM_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_minimum = rsp_minimum_ff;
   assign rsp_status  = rsp_status_ff;

   `STRM_ASSERT_IMPLIES(a_build_stage_empty, clock, reset, bld_busy_ff, !s1_valid_ff, "result stage busy during a build")
   `STRM_ASSERT_NEVER(a_write_port_clash, clock, reset, bw_valid_ff && pop_load, "build write and load write collide")
   `STRM_ASSERT_IMPLIES(a_read_data_held, clock, reset, s1_valid_ff && !out_ready, !ram_rd_en, "read data overwritten while a result waits")

endmodule

// ===== hw/rtl/sparse_table_range_minimum.sv =====
// A query word goes through the command queue, the result stage that reads the table
// and the response register. Throughput: one load, query or reply word per cycle
// while no build runs and rsp_stall is low. A build of n elements walks levels 1..K.
// Reset clears the built mark, the queue, the build sequencer and the response register,
// and sets the element count to 1024; table contents are not cleared.
// Top level of the sparse table range minimum block.
module sparse_table_range_minimum import strm_pkg::*; #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int LEVELS       = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0]        req_left,
   input  logic [POS_W-1:0]        req_right,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_minimum,
   output logic [STATUS_W-1:0]     rsp_status,
   input  logic                    csr_wr_en,
   input  logic [CSR_W-1:0]        csr_wr_data
);

   // Element index width, level width and a count width that holds both the
   // register value and the table size.
   localparam int IDX_W  = $clog2(MAX_ELEMENTS);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int CNT_W0 = $clog2(MAX_ELEMENTS + 1);
   localparam int CNT_W  = (CNT_W0 > CSR_W) ? CNT_W0 : CSR_W;
   localparam int CMD_W  = $bits(cmd_ctl_type) + LVL_W + 2 * IDX_W + VAL_W;

   // Front end outputs. The front end decides every status up front, since the
   // built mark evolves in word order and does not depend on the table data.
   logic                    fe_push;
   cmd_ctl_type             fe_ctl;
   logic [LVL_W-1:0]        fe_level;
   logic [IDX_W-1:0]        fe_addr_a;
   logic [IDX_W-1:0]        fe_addr_b;
   logic signed [VAL_W-1:0] fe_value;
   logic [CNT_W-1:0]        active_count;

   // Queue signals between the two halves.
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic [CMD_W-1:0] q_push_data;
   logic [CMD_W-1:0] q_pop_data;

   // Back end view of the queue head.
   cmd_ctl_type             be_ctl;
   logic [LVL_W-1:0]        be_level;
   logic [IDX_W-1:0]        be_addr_a;
   logic [IDX_W-1:0]        be_addr_b;
   logic signed [VAL_W-1:0] be_value;

   strm_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVELS       (LEVELS),
      .IDX_W        (IDX_W),
      .LVL_W        (LVL_W),
      .CNT_W        (CNT_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_position  (req_position),
      .req_value     (req_value),
      .req_left      (req_left),
      .req_right     (req_right),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_full        (q_full),
      .q_push        (fe_push),
      .cmd_ctl       (fe_ctl),
      .cmd_level     (fe_level),
      .cmd_addr_a    (fe_addr_a),
      .cmd_addr_b    (fe_addr_b),
      .cmd_value     (fe_value),
      .active_count  (active_count)
   );

   // A classified command is packed into one queue word.
   assign q_push_data = {fe_ctl, fe_level, fe_addr_a, fe_addr_b, fe_value};

   strm_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   assign {be_ctl, be_level, be_addr_a, be_addr_b, be_value} = q_pop_data;

   // The back end owns the table memory. It stops popping while a build walks
   // the levels, and while a finished result waits for the response register.
   strm_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LEVELS       (LEVELS),
      .IDX_W        (IDX_W),
      .LVL_W        (LVL_W),
      .CNT_W        (CNT_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (!q_empty),
      .q_pop        (q_pop),
      .cmd_ctl      (be_ctl),
      .cmd_level    (be_level),
      .cmd_addr_a   (be_addr_a),
      .cmd_addr_b   (be_addr_b),
      .cmd_value    (be_value),
      .active_count (active_count),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_minimum  (rsp_minimum),
      .rsp_status   (rsp_status)
   );

endmodule
